>>> rtl/cth_pkg.sv
// ----------------------------------------------------------------------------
// cth_pkg
// Shared types and constants for the coincidence time histogrammer.
// ----------------------------------------------------------------------------
package cth_pkg;

  localparam int TIME_W  = 24;
  localparam int CHAN_W  = 3;
  localparam int BINIX_W = 7;
  localparam int COUNT_W = 32;
  localparam int CFG_IX_W = 2;

  localparam int DEF_NUM_BINS        = 100;
  localparam int DEF_NUM_CHANNELS    = 8;
  localparam int DEF_REFERENCE_DEPTH = 16;

  localparam logic [TIME_W-1:0] WINDOW_RESET    = 24'd10000;
  localparam logic [TIME_W-1:0] BLOCK_LEN_RESET = 24'd10000000;
  localparam logic [CHAN_W-1:0] REF_CHAN_RESET  = 3'd0;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_WINDOW    = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_BLOCK_LEN = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_REF_CHAN  = 2'd2;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [CHAN_W-1:0]  channel;
    logic [TIME_W-1:0]  hit_time;
    logic               hist_select;
    logic [BINIX_W-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic               in_window;
    logic [TIME_W-1:0]  time_difference;
    logic [COUNT_W-1:0] bin_count;
  } out_item_t;

  // one entry of the reference time chain
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] ref_time;
  } ref_entry_t;

  // chain control from the sequencer
  typedef struct packed {
    logic              shift;
    logic              append;
    logic [TIME_W-1:0] din;
  } chain_ctrl_t;

endpackage

>>> rtl/cth_ref_cell.sv
// ----------------------------------------------------------------------------
// cth_ref_cell
// One slot of the reference time chain; shifts toward the head on a drop or on an append to a full chain.
// ----------------------------------------------------------------------------
module cth_ref_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                head,
  input  cth_pkg::chain_ctrl_t ctrl,
  input  logic                prev_valid,
  input  cth_pkg::ref_entry_t nxt,
  output cth_pkg::ref_entry_t cur
);

  logic first_free;

  // first empty slot after this cycle's shift
  always_comb begin
    if (ctrl.shift) begin
      first_free = !nxt.valid && (head || cur.valid);
    end else begin
      first_free = !cur.valid && prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (ctrl.append && first_free) begin
      cur.valid <= 1'b1;
      cur.ref_time <= ctrl.din;
    end else if (ctrl.shift) begin
      cur <= nxt;
    end
  end

endmodule

>>> rtl/cth_divider.sv
// ----------------------------------------------------------------------------
// cth_divider
// Restoring divider, one quotient bit per cycle; quotient below NUM_BINS.
// ----------------------------------------------------------------------------
module cth_divider #(
  parameter int NUM_BINS = cth_pkg::DEF_NUM_BINS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [cth_pkg::TIME_W+$clog2(NUM_BINS+1)-1:0] dividend,
  input  logic [cth_pkg::TIME_W-1:0]                  divisor,
  output logic                                        done,
  output logic [$clog2(NUM_BINS)-1:0]                 quotient
);

  localparam int NW = cth_pkg::TIME_W + $clog2(NUM_BINS + 1);
  localparam int QW = $clog2(NUM_BINS);
  localparam int DW = NW + QW;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= DW'(dividend);
        dsh      <= DW'(divisor) << (QW - 1);
        quotient <= '0;
        cnt      <= CW'(QW);
        busy     <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quotient <= {quotient[QW-2 >= 0 ? QW-2 : 0:0], fits} & QW'({QW{1'b1}});
        dsh      <= dsh >> 1;
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/coincidence_time_histogrammer_unit.sv
// ----------------------------------------------------------------------------
// coincidence_time_histogrammer_unit
// Counts hits into per-channel block-time and event-time histograms, matching
// each hit against a chain of recent reference times; also reads bins back.
// ----------------------------------------------------------------------------
//  channel | signals                        | beat
//  in      | in_valid, in_ready, in_data    | one hit record or bin read
//  out     | out_valid, out_ready, out_data | one result per input beat
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
//  Steps: a recorded hit first drops each expired reference, then, for a
//  valid channel, updates the block histogram, or its overflow bin without
//  the divider, then the event histogram on a match, or appends its time
//  when the hit comes on the reference channel. The quotient divider gives
//  the bin of each in-range update, one bit per cycle.
//  Reset: a clearing pass writes all NUM_CHANNELS*2*(NUM_BINS+2) histogram
//  bins (1632 by default) to zero; in_ready is low.
//  Stalls: in_ready returns while a finished result still waits on out.
// ----------------------------------------------------------------------------
module coincidence_time_histogrammer_unit #(
  parameter int NUM_BINS        = cth_pkg::DEF_NUM_BINS,
  parameter int NUM_CHANNELS    = cth_pkg::DEF_NUM_CHANNELS,
  parameter int REFERENCE_DEPTH = cth_pkg::DEF_REFERENCE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cth_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cth_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cth_pkg::CFG_IX_W-1:0]     cfg_index,
  input  logic [cth_pkg::TIME_W-1:0]       cfg_data
);

  localparam int BPH   = NUM_BINS + 2;
  localparam int DEPTH = NUM_CHANNELS * 2 * BPH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = cth_pkg::TIME_W + $clog2(NUM_BINS + 1);
  localparam int QW    = $clog2(NUM_BINS);
  localparam int TW    = cth_pkg::TIME_W;
  localparam int CNTW  = cth_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DROP, S_DIV, S_DWAIT, S_READ, S_WRITE,
    S_EVAL, S_APPEND, S_RREAD, S_RDATA, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [TW-1:0]              window_ns;
  logic [TW-1:0]              block_length_ns;
  logic [cth_pkg::CHAN_W-1:0] reference_channel;

  // current item and result
  cth_pkg::in_item_t  item;
  logic               res_win;
  logic [TW-1:0]      res_diff;
  logic [CNTW-1:0]    res_count;
  logic               ev_phase;

  // histogram memory
  logic [CNTW-1:0] hist_mem [DEPTH];
  logic [AW-1:0]   mem_addr;
  logic [CNTW-1:0] mem_rdata;
  logic            mem_we;
  logic [CNTW-1:0] mem_wdata;

  // reference chain
  cth_pkg::ref_entry_t cells [REFERENCE_DEPTH];
  cth_pkg::chain_ctrl_t chain_ctrl;
  cth_pkg::ref_entry_t front;
  logic                full;

  // divider
  logic            div_start;
  logic [NW-1:0]   div_dividend;
  logic [TW-1:0]   div_divisor;
  logic            div_done;
  logic [QW-1:0]   div_q;

  logic            chan_ok;
  logic            expired;
  logic            ref_match;
  logic [TW-1:0]   cur_diff;
  logic [31:0]     rd_addr;
  logic [31:0]     bump_addr;
  logic [31:0]     ovf_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ns         <= cth_pkg::WINDOW_RESET;
      block_length_ns   <= cth_pkg::BLOCK_LEN_RESET;
      reference_channel <= cth_pkg::REF_CHAN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cth_pkg::CFG_WINDOW:    window_ns         <= cfg_data;
        cth_pkg::CFG_BLOCK_LEN: block_length_ns   <= cfg_data;
        cth_pkg::CFG_REF_CHAN:  reference_channel <= cfg_data[cth_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // reference chain: head is cell 0
  assign front = cells[0];
  assign full  = cells[REFERENCE_DEPTH-1].valid;

  genvar gi;
  generate
    for (gi = 0; gi < REFERENCE_DEPTH; gi++) begin : g_cell
      cth_pkg::ref_entry_t nxt;
      logic                pv;
      if (gi == REFERENCE_DEPTH - 1) begin : g_tail
        assign nxt = '0;
      end else begin : g_mid
        assign nxt = cells[gi+1];
      end
      if (gi == 0) begin : g_head
        assign pv = 1'b1;
      end else begin : g_body
        assign pv = cells[gi-1].valid;
      end
      cth_ref_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .head       (gi == 0),
        .ctrl       (chain_ctrl),
        .prev_valid (pv),
        .nxt        (nxt),
        .cur        (cells[gi])
      );
    end
  endgenerate

  cth_divider #(.NUM_BINS(NUM_BINS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // decode
  assign chan_ok   = 32'(item.channel) < 32'(NUM_CHANNELS);
  assign expired   = front.valid &&
                     ({1'b0, item.hit_time} >= {1'b0, front.ref_time} + {1'b0, window_ns});
  assign ref_match = front.valid && (front.ref_time <= item.hit_time);
  assign cur_diff  = item.hit_time - front.ref_time;

  assign rd_addr   = (32'(in_data.channel) * 2 + 32'(in_data.hist_select)) * 32'(BPH)
                     + 32'(in_data.bin_index);
  assign bump_addr = (32'(item.channel) * 2 + 32'(ev_phase)) * 32'(BPH)
                     + 32'(div_q) + 32'd1;
  assign ovf_addr  = 32'(item.channel) * 2 * 32'(BPH) + 32'(NUM_BINS + 1);

  assign div_start    = (state == S_DIV);
  assign div_dividend = ev_phase ? NW'(res_diff) * NW'(NUM_BINS)
                                 : NW'(item.hit_time) * NW'(NUM_BINS);
  assign div_divisor  = ev_phase ? window_ns : block_length_ns;

  always_comb begin
    chain_ctrl.shift  = 1'b0;
    chain_ctrl.append = 1'b0;
    chain_ctrl.din    = item.hit_time;
    if (state == S_DROP) begin
      chain_ctrl.shift = expired;
    end else if (state == S_APPEND) begin
      chain_ctrl.shift  = full;
      chain_ctrl.append = 1'b1;
    end
  end

  // saturating increment, or zero during the clearing pass
  assign mem_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign mem_wdata = (state == S_CLEAR) ? '0 :
                     (&mem_rdata) ? mem_rdata : mem_rdata + CNTW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= hist_mem[mem_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      mem_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_DONE reloads the output itself when the held beat leaves
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          mem_addr <= mem_addr + AW'(1);
          if (32'(mem_addr) == 32'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item      <= in_data;
            res_win   <= 1'b0;
            res_diff  <= '0;
            res_count <= '0;
            ev_phase  <= 1'b0;
            if (in_data.mode == cth_pkg::MODE_READ) begin
              mem_addr <= rd_addr[AW-1:0];
              if (32'(in_data.channel) < 32'(NUM_CHANNELS) &&
                  32'(in_data.bin_index) < 32'(BPH)) begin
                state <= S_RREAD;
              end else begin
                state <= S_DONE;
              end
            end else begin
              state <= S_DROP;
            end
          end
        end
        S_DROP: begin
          if (!expired) begin
            if (!chan_ok) begin
              state <= S_EVAL;
            end else if (item.hit_time >= block_length_ns) begin
              mem_addr <= ovf_addr[AW-1:0];
              state    <= S_READ;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV:   state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            mem_addr <= bump_addr[AW-1:0];
            state    <= S_READ;
          end
        end
        S_READ:  state <= S_WRITE;
        S_WRITE: state <= ev_phase ? S_DONE : S_EVAL;
        S_EVAL: begin
          if (item.channel == reference_channel) begin
            state <= S_APPEND;
          end else if (ref_match) begin
            res_win  <= 1'b1;
            res_diff <= cur_diff;
            ev_phase <= 1'b1;
            state    <= chan_ok ? S_DIV : S_DONE;
          end else begin
            state <= S_DONE;
          end
        end
        S_APPEND: state <= S_DONE;
        S_RREAD:  state <= S_RDATA;
        S_RDATA: begin
          res_count <= mem_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.in_window       <= res_win;
            out_data.time_difference <= res_diff;
            out_data.bin_count       <= res_count;
            out_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
